[rtl/core/hsv_to_rgb_converter_macros.svh]
// Assertion macros used by the checker of the HSV to RGB converter.
`ifndef HSV_TO_RGB_CONVERTER_MACROS_SVH
`define HSV_TO_RGB_CONVERTER_MACROS_SVH

// Same-cycle implication, disabled while reset is low.
`define HSV_ASSERT_IMP(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is low.
`define HSV_ASSERT_NXT(label, clock, rstn, ante, cons, msg) \
	label: assert property (@(posedge clock) disable iff (!rstn) (ante) |=> (cons)) \
		else $error(msg);

// Same-cycle implication that is also checked during reset.
`define HSV_ASSERT_ALW(label, clock, ante, cons, msg) \
	label: assert property (@(posedge clock) (ante) |-> (cons)) \
		else $error(msg);

`endif

[rtl/core/hsv_pkg.sv]
// Types and constants of the HSV to RGB converter.
`default_nettype none

package hsv_pkg;

	// Hue is Q9.6 degrees; a full turn and one sector in those units.
	typedef logic [14:0] hue_t;
	localparam hue_t HUE_TURN   = 15'd23040;
	localparam hue_t HUE_SECTOR = 15'd3840;

	localparam int HUE_REM_W = 12;
	localparam int CHAN_W    = 13;

	// Sector of the hexcone, named after the leading and the ramping (rising or falling) channel.
	typedef enum logic [2:0] {
		SEC_RED_GRN = 3'd0,
		SEC_GRN_RED = 3'd1,
		SEC_GRN_BLU = 3'd2,
		SEC_BLU_GRN = 3'd3,
		SEC_BLU_RED = 3'd4,
		SEC_RED_BLU = 3'd5
	} sector_t;

endpackage

`default_nettype wire

[rtl/core/hsv_mul.sv]
// Registered unsigned multiplier whose product is truncated by a right shift.
`default_nettype none

module hsv_mul #(
	parameter int AW    = 13,
	parameter int BW    = 13,
	parameter int SHIFT = 12,
	parameter int OW    = 13
) (
	input  wire logic          clk,
	input  wire logic          en,
	input  wire logic [AW-1:0] a,
	input  wire logic [BW-1:0] b,
	output logic      [OW-1:0] prod
);

	logic [AW+BW-1:0] full;

	assign full = (AW+BW)'(a) * (AW+BW)'(b);

	always_ff @(posedge clk) begin
		if (en) begin
			prod <= OW'(full >> SHIFT);
		end
	end

endmodule

`default_nettype wire

[rtl/core/hsv_to_rgb_converter.sv]
// HSV to RGB converter: six-stage pipeline, one color per clock unless the output stalls.
// Each input transfer passes through stages 1 to 6 in order before its result reaches the master side.
// Throughput: one item per cycle unless the output stalls; each stage advances when it is
// empty or when the stage after it advances, so bubbles close up behind a stalled output.
// Reset: arst_n clears every stage valid bit at once; data registers keep junk.
`default_nettype none

module hsv_to_rgb_converter import hsv_pkg::*; #(
	parameter int COLOR_FRAC_BITS = 12
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	// hue_deg[15:0], saturation[28:16], brightness[41:29], zero pad above
	input  wire logic [47:0] s_axis_tdata,
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	// red[12:0], green[25:13], blue[38:26], zero pad above
	output logic      [39:0] m_axis_tdata,
	// range_error[0]
	output logic             m_axis_tuser
);

	localparam int F  = COLOR_FRAC_BITS;
	localparam int CW = F + 1;
	localparam int XW = (CW > CHAN_W) ? CW : CHAN_W;
	localparam logic [CW-1:0] ONE = CW'(1) << F;

	// Sector fraction: f = floor(rem * 2^F / 3840) = floor((rem << (F-8)) / 15),
	// done as a multiply by a rounded-up reciprocal, exact for every remainder.
	localparam int YW = F + 4;
	localparam int K  = F + 8;
	localparam int MW = F + 5;
	localparam logic [MW-1:0] RECIP15 = MW'(((64'd1 << K) + 64'd14) / 64'd15);

	// Input fields.
	logic [15:0]        hue_in;
	logic [CHAN_W-1:0]  sat_in;
	logic [CHAN_W-1:0]  val_in;

	assign hue_in = s_axis_tdata[15:0];
	assign sat_in = s_axis_tdata[28:16];
	assign val_in = s_axis_tdata[41:29];

	// Stage advance chain.
	logic valid_s1, valid_s2, valid_s3, valid_s4, valid_s5, valid_s6;
	logic adv_s1, adv_s2, adv_s3, adv_s4, adv_s5, adv_s6;

	assign adv_s6 = !valid_s6 || m_axis_tready;
	assign adv_s5 = !valid_s5 || adv_s6;
	assign adv_s4 = !valid_s4 || adv_s5;
	assign adv_s3 = !valid_s3 || adv_s4;
	assign adv_s2 = !valid_s2 || adv_s3;
	assign adv_s1 = !valid_s1 || adv_s2;

	assign s_axis_tready = adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
			valid_s6 <= 1'b0;
		end else begin
			if (adv_s1) valid_s1 <= s_axis_tvalid;
			if (adv_s2) valid_s2 <= valid_s1;
			if (adv_s3) valid_s3 <= valid_s2;
			if (adv_s4) valid_s4 <= valid_s3;
			if (adv_s5) valid_s5 <= valid_s4;
			if (adv_s6) valid_s6 <= valid_s5;
		end
	end

	// Stage 1: range check and hue wrap. A non-negative hue is below two turns.
	logic          err_c;
	hue_t          hue_wrap_c;
	logic          err_s1;
	hue_t          hue_s1;
	logic [CW-1:0] sat_s1, val_s1;

	assign err_c = hue_in[15] || (XW'(sat_in) > XW'(ONE)) || (XW'(val_in) > XW'(ONE));
	assign hue_wrap_c = (hue_in[14:0] >= HUE_TURN) ? (hue_in[14:0] - HUE_TURN) : hue_in[14:0];

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			err_s1 <= err_c;
			hue_s1 <= hue_wrap_c;
			sat_s1 <= CW'(sat_in);
			val_s1 <= CW'(val_in);
		end
	end

	// Stage 2: sector and remainder within the sector.
	sector_t              sector_c;
	hue_t                 base_c;
	logic                 err_s2;
	sector_t              sector_s2;
	logic [HUE_REM_W-1:0] rem_s2;
	logic [CW-1:0]        sat_s2, val_s2;

	always_comb begin
		if (hue_s1 >= HUE_SECTOR * 15'd5) begin
			sector_c = SEC_RED_BLU;
			base_c   = HUE_SECTOR * 15'd5;
		end else if (hue_s1 >= HUE_SECTOR * 15'd4) begin
			sector_c = SEC_BLU_RED;
			base_c   = HUE_SECTOR * 15'd4;
		end else if (hue_s1 >= HUE_SECTOR * 15'd3) begin
			sector_c = SEC_BLU_GRN;
			base_c   = HUE_SECTOR * 15'd3;
		end else if (hue_s1 >= HUE_SECTOR * 15'd2) begin
			sector_c = SEC_GRN_BLU;
			base_c   = HUE_SECTOR * 15'd2;
		end else if (hue_s1 >= HUE_SECTOR) begin
			sector_c = SEC_GRN_RED;
			base_c   = HUE_SECTOR;
		end else begin
			sector_c = SEC_RED_GRN;
			base_c   = '0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s2) begin
			err_s2    <= err_s1;
			sector_s2 <= sector_c;
			rem_s2    <= HUE_REM_W'(hue_s1 - base_c);
			sat_s2    <= sat_s1;
			val_s2    <= val_s1;
		end
	end

	// Stage 3: sector fraction and p = val * (1 - sat).
	logic [YW-1:0] rem_scaled;
	logic [F-1:0]  f_s3;
	logic [CW-1:0] p_s3;
	logic          err_s3;
	sector_t       sector_s3;
	logic [CW-1:0] sat_s3, val_s3;

	assign rem_scaled = YW'(rem_s2) << (F - 8);

	hsv_mul #(.AW(YW), .BW(MW), .SHIFT(K), .OW(F)) u_frac (
		.clk  (clk),
		.en   (adv_s3),
		.a    (rem_scaled),
		.b    (RECIP15),
		.prod (f_s3)
	);

	hsv_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(CW)) u_p (
		.clk  (clk),
		.en   (adv_s3),
		.a    (val_s2),
		.b    (ONE - sat_s2),
		.prod (p_s3)
	);

	always_ff @(posedge clk) begin
		if (adv_s3) begin
			err_s3    <= err_s2;
			sector_s3 <= sector_s2;
			sat_s3    <= sat_s2;
			val_s3    <= val_s2;
		end
	end

	// Stage 4: sat * f and sat * (1 - f).
	logic [CW-1:0] sf_s4, sfc_s4, p_s4, val_s4;
	logic          err_s4;
	sector_t       sector_s4;

	hsv_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(CW)) u_sf (
		.clk  (clk),
		.en   (adv_s4),
		.a    (sat_s3),
		.b    (CW'(f_s3)),
		.prod (sf_s4)
	);

	hsv_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(CW)) u_sfc (
		.clk  (clk),
		.en   (adv_s4),
		.a    (sat_s3),
		.b    (ONE - CW'(f_s3)),
		.prod (sfc_s4)
	);

	always_ff @(posedge clk) begin
		if (adv_s4) begin
			err_s4    <= err_s3;
			sector_s4 <= sector_s3;
			p_s4      <= p_s3;
			val_s4    <= val_s3;
		end
	end

	// Stage 5: falling ramp q and rising ramp u.
	logic [CW-1:0] q_s5, u_s5, p_s5, val_s5;
	logic          err_s5;
	sector_t       sector_s5;

	hsv_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(CW)) u_q (
		.clk  (clk),
		.en   (adv_s5),
		.a    (val_s4),
		.b    (ONE - sf_s4),
		.prod (q_s5)
	);

	hsv_mul #(.AW(CW), .BW(CW), .SHIFT(F), .OW(CW)) u_u (
		.clk  (clk),
		.en   (adv_s5),
		.a    (val_s4),
		.b    (ONE - sfc_s4),
		.prod (u_s5)
	);

	always_ff @(posedge clk) begin
		if (adv_s5) begin
			err_s5    <= err_s4;
			sector_s5 <= sector_s4;
			p_s5      <= p_s4;
			val_s5    <= val_s4;
		end
	end

	// Stage 6: route the four levels to the channels, zeroed for a rejected color, and hold the result.
	logic [CW-1:0]     red_c, green_c, blue_c;
	logic [CHAN_W-1:0] red_s6, green_s6, blue_s6;
	logic              err_s6;

	always_comb begin
		case (sector_s5)
			SEC_RED_GRN: begin
				red_c = val_s5; green_c = u_s5;   blue_c = p_s5;
			end
			SEC_GRN_RED: begin
				red_c = q_s5;   green_c = val_s5; blue_c = p_s5;
			end
			SEC_GRN_BLU: begin
				red_c = p_s5;   green_c = val_s5; blue_c = u_s5;
			end
			SEC_BLU_GRN: begin
				red_c = p_s5;   green_c = q_s5;   blue_c = val_s5;
			end
			SEC_BLU_RED: begin
				red_c = u_s5;   green_c = p_s5;   blue_c = val_s5;
			end
			default: begin
				red_c = val_s5; green_c = p_s5;   blue_c = q_s5;
			end
		endcase
	end

	always_ff @(posedge clk) begin
		if (adv_s6) begin
			err_s6   <= err_s5;
			red_s6   <= err_s5 ? '0 : CHAN_W'(red_c);
			green_s6 <= err_s5 ? '0 : CHAN_W'(green_c);
			blue_s6  <= err_s5 ? '0 : CHAN_W'(blue_c);
		end
	end

	assign m_axis_tvalid = valid_s6;
	assign m_axis_tdata  = {1'b0, blue_s6, green_s6, red_s6};
	assign m_axis_tuser  = err_s6;

endmodule

`default_nettype wire

[rtl/core/hsv_checker.sv]
// Port-level checker for the HSV to RGB converter and its bind statement.
`default_nettype none

`include "hsv_to_rgb_converter_macros.svh"

module hsv_checker #(
	parameter int COLOR_FRAC_BITS = 12
) (
	input wire logic        clk,
	input wire logic        arst_n,
	input wire logic        s_axis_tready,
	input wire logic        m_axis_tvalid,
	input wire logic        m_axis_tready,
	input wire logic [39:0] m_axis_tdata,
	input wire logic        m_axis_tuser
);

	// Largest channel value that a valid color can produce in 13 bits.
	localparam logic [12:0] CHAN_MAX =
		(COLOR_FRAC_BITS >= 13) ? 13'h1FFF : 13'(1 << COLOR_FRAC_BITS);

	`HSV_ASSERT_ALW(a_reset_clears_out, clk, !arst_n, !m_axis_tvalid, "output valid during reset")

	`HSV_ASSERT_NXT(a_stall_holds, clk, arst_n, m_axis_tvalid && !m_axis_tready, m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser), "stalled result changed")

	`HSV_ASSERT_IMP(a_error_zero_rgb, clk, arst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == 40'd0, "rejected color has nonzero channels")

	`HSV_ASSERT_IMP(a_channel_range, clk, arst_n, m_axis_tvalid && !m_axis_tuser, (m_axis_tdata[12:0] <= CHAN_MAX) && (m_axis_tdata[25:13] <= CHAN_MAX) && (m_axis_tdata[38:26] <= CHAN_MAX) && !m_axis_tdata[39], "channel above full intensity")

	// When the output stage can move, every stage can move and the input is open.
	`HSV_ASSERT_IMP(a_ready_when_drained, clk, arst_n, !m_axis_tvalid || m_axis_tready, s_axis_tready, "input blocked while output can move")

endmodule

bind hsv_to_rgb_converter hsv_checker #(.COLOR_FRAC_BITS(COLOR_FRAC_BITS)) u_hsv_checker (
	.clk           (clk),
	.arst_n        (arst_n),
	.s_axis_tready (s_axis_tready),
	.m_axis_tvalid (m_axis_tvalid),
	.m_axis_tready (m_axis_tready),
	.m_axis_tdata  (m_axis_tdata),
	.m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

[tb/hsv_to_rgb_converter_tb.sv]
// Self-checking testbench of the HSV to RGB converter with random idling on both streams.
`default_nettype none

module hsv_to_rgb_converter_tb;
	import hsv_pkg::*;

	localparam int FRAC_BITS = 12;
	localparam logic [12:0] UNIT = 13'd4096;
	localparam int ITEM_COUNT = 1450;

	typedef struct packed {
		logic [15:0] hue;
		logic [12:0] sat;
		logic [12:0] val;
		logic        drain_first;
	} hsv_item_t;

	typedef struct packed {
		logic [12:0] red;
		logic [12:0] green;
		logic [12:0] blue;
		logic        range_error;
	} rgb_color_t;

	logic        clk;
	logic        arst_n;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [47:0] s_axis_tdata;
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	logic [39:0] m_axis_tdata;
	logic        m_axis_tuser;

	hsv_item_t   hsv_pending[$];
	rgb_color_t  rgb_expected[$];
	hsv_item_t   drive_item;
	rgb_color_t  got_color;
	rgb_color_t  want_color;
	logic        in_taken;
	int          gap_left;
	int          stall_left;
	bit          in_burst;
	bit          out_burst;
	int          errors;

	hsv_to_rgb_converter #(
		.COLOR_FRAC_BITS(FRAC_BITS)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata (s_axis_tdata),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata (m_axis_tdata),
		.m_axis_tuser (m_axis_tuser)
	);

	always #5 clk = ~clk;

	// Hexcone conversion with every product truncated to the channel format.
	function automatic rgb_color_t hsv_to_rgb_predict(logic [15:0] hue, logic [12:0] sat,
			logic [12:0] val);
		rgb_color_t       color;
		longint unsigned  h;
		longint unsigned  rem;
		longint unsigned  frac;
		longint unsigned  p;
		longint unsigned  q;
		longint unsigned  u;
		longint unsigned  v;
		sector_t          sec;
		color = '0;
		if (hue[15] || sat > UNIT || val > UNIT) begin
			color.range_error = 1'b1;
			return color;
		end
		v = 64'(val);
		h = longint'(hue) % longint'(HUE_TURN);
		sec = sector_t'(h / longint'(HUE_SECTOR));
		rem = h % longint'(HUE_SECTOR);
		frac = (rem << FRAC_BITS) / longint'(HUE_SECTOR);
		p = (v * (UNIT - sat)) >> FRAC_BITS;
		q = (v * (UNIT - ((sat * frac) >> FRAC_BITS))) >> FRAC_BITS;
		u = (v * (UNIT - ((sat * (UNIT - frac)) >> FRAC_BITS))) >> FRAC_BITS;
		case (sec)
			SEC_RED_GRN: begin color.red = 13'(v); color.green = 13'(u); color.blue = 13'(p); end
			SEC_GRN_RED: begin color.red = 13'(q); color.green = 13'(v); color.blue = 13'(p); end
			SEC_GRN_BLU: begin color.red = 13'(p); color.green = 13'(v); color.blue = 13'(u); end
			SEC_BLU_GRN: begin color.red = 13'(p); color.green = 13'(q); color.blue = 13'(v); end
			SEC_BLU_RED: begin color.red = 13'(u); color.green = 13'(p); color.blue = 13'(v); end
			default:     begin color.red = 13'(v); color.green = 13'(p); color.blue = 13'(q); end
		endcase
		return color;
	endfunction

	function automatic int idle_len(bit burst);
		int r;
		if (burst)
			return 0;
		r = $urandom_range(99);
		if (r < 60)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	function automatic logic [12:0] pick_level();
		int r;
		r = $urandom_range(9);
		if (r == 0)
			return 13'd0;
		if (r == 1)
			return UNIT;
		return 13'($urandom_range(0, UNIT));
	endfunction

	// Mostly legal colors, with hues pushed onto sector borders now and then.
	function automatic hsv_item_t random_item();
		hsv_item_t it;
		int r;
		it = '0;
		r = $urandom_range(99);
		if (r < 20) begin
			it.hue = 16'($urandom());
			it.sat = 13'($urandom());
			it.val = 13'($urandom());
		end else begin
			if (r < 32)
				it.hue = 16'($urandom_range(1, 8) * 3840 + $urandom_range(0, 2) - 1);
			else
				it.hue = 16'($urandom_range(0, 32767));
			it.sat = pick_level();
			it.val = pick_level();
		end
		return it;
	endfunction

	function automatic hsv_item_t make_item(logic [15:0] hue, logic [12:0] sat,
			logic [12:0] val);
		hsv_item_t it;
		it.hue = hue;
		it.sat = sat;
		it.val = val;
		it.drain_first = 1'b0;
		return it;
	endfunction

	// Both streams: input items and output ready change at the falling edge; transfers complete at rising edges.
	always @(negedge clk) begin
		if (arst_n) begin
			if (!s_axis_tvalid || in_taken) begin
				if (gap_left > 0) begin
					gap_left--;
					s_axis_tvalid <= 1'b0;
				end else if (hsv_pending.size() > 0 &&
						!(hsv_pending[0].drain_first && rgb_expected.size() > 0)) begin
					drive_item = hsv_pending.pop_front();
					s_axis_tdata <= {6'd0, drive_item.val, drive_item.sat, drive_item.hue};
					s_axis_tvalid <= 1'b1;
					if ($urandom_range(199) == 0)
						in_burst = !in_burst;
					gap_left = idle_len(in_burst);
				end else begin
					s_axis_tvalid <= 1'b0;
				end
			end
			if (stall_left > 0) begin
				stall_left--;
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
				if ($urandom_range(199) == 0)
					out_burst = !out_burst;
				stall_left = idle_len(out_burst);
			end
		end
	end

	always @(posedge clk) begin
		in_taken = s_axis_tvalid && s_axis_tready;
		if (m_axis_tvalid && m_axis_tready) begin
			got_color = {m_axis_tdata[12:0], m_axis_tdata[25:13], m_axis_tdata[38:26],
				m_axis_tuser};
			if (rgb_expected.size() == 0) begin
				$error("unexpected result transfer: tdata %h tuser %b", m_axis_tdata,
					m_axis_tuser);
				errors++;
			end else begin
				want_color = rgb_expected.pop_front();
				if (got_color.red !== want_color.red) begin
					$error("red: expected %0d, got %0d", want_color.red, got_color.red);
					errors++;
				end
				if (got_color.green !== want_color.green) begin
					$error("green: expected %0d, got %0d", want_color.green, got_color.green);
					errors++;
				end
				if (got_color.blue !== want_color.blue) begin
					$error("blue: expected %0d, got %0d", want_color.blue, got_color.blue);
					errors++;
				end
				if (got_color.range_error !== want_color.range_error) begin
					$error("range_error: expected %0d, got %0d", want_color.range_error,
						got_color.range_error);
					errors++;
				end
			end
		end
		if (in_taken)
			rgb_expected.push_back(hsv_to_rgb_predict(s_axis_tdata[15:0],
				s_axis_tdata[28:16], s_axis_tdata[41:29]));
	end

	initial begin
		hsv_item_t it;
		clk = 1'b0;
		arst_n = 1'b1;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		m_axis_tready = 1'b0;
		in_taken = 1'b0;
		gap_left = 0;
		stall_left = 0;
		in_burst = 1'b0;
		out_burst = 1'b0;
		errors = 0;

		// The reset falls a moment after start so that every register sees the edge.
		#1;
		arst_n = 1'b0;

		// Sector borders, the wrap at a full turn, and every rejected range.
		hsv_pending.push_back(make_item(16'd0, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd1, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd3839, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd3840, 13'd2048, UNIT));
		hsv_pending.push_back(make_item(16'd9600, 13'd3000, 13'd4000));
		hsv_pending.push_back(make_item(16'd13440, 13'd1234, 13'd3210));
		hsv_pending.push_back(make_item(16'd17280, UNIT, 13'd2047));
		hsv_pending.push_back(make_item(16'd21120, 13'd4095, UNIT));
		hsv_pending.push_back(make_item(16'd23039, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd23040, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd26880, 13'd2000, 13'd2000));
		hsv_pending.push_back(make_item(16'd32767, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'd5000, 13'd0, UNIT));
		hsv_pending.push_back(make_item(16'd5000, UNIT, 13'd0));
		hsv_pending.push_back(make_item(16'd5000, 13'd0, 13'd0));
		hsv_pending.push_back(make_item(16'hFFFF, UNIT, UNIT));
		hsv_pending.push_back(make_item(16'h8000, 13'd0, 13'd0));
		hsv_pending.push_back(make_item(16'd100, 13'd4097, UNIT));
		hsv_pending.push_back(make_item(16'd100, 13'd8191, UNIT));
		hsv_pending.push_back(make_item(16'd100, UNIT, 13'd4097));
		hsv_pending.push_back(make_item(16'd100, UNIT, 13'd8191));
		hsv_pending.push_back(make_item(16'hFFFF, 13'd8191, 13'd8191));

		for (int i = 0; i < ITEM_COUNT; i++) begin
			it = random_item();
			it.drain_first = (i == 0 || i == ITEM_COUNT / 2);
			hsv_pending.push_back(it);
		end

		repeat (11) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		do
			@(negedge clk);
		while (hsv_pending.size() > 0 || s_axis_tvalid || rgb_expected.size() > 0);
		repeat (12) @(posedge clk);

		if (errors == 0)
			$display("hsv_to_rgb_converter_tb OK");
		else
			$display("hsv_to_rgb_converter_tb NOT OK");
		$finish;
	end

	initial begin
		#5000000;
		$display("hsv_to_rgb_converter_tb NOT OK");
		$finish;
	end

endmodule

`default_nettype wire
